[sv/p2c_pkg.sv]
// shared types, constants and arithmetic helpers for the primitive to conservative block
package p2c_pkg;

  localparam int unsigned DATA_W  = 48;
  localparam int unsigned PROD_W  = 96;
  localparam int unsigned GAS_W   = 47;
  localparam int unsigned HEAT_W  = 26;
  localparam int unsigned LANES   = 5;

  localparam logic [GAS_W-1:0]  GAS_RESET  = 47'd4815060992;
  localparam logic [HEAT_W-1:0] HEAT_RESET = 26'd23488102;
  localparam logic [46:0]       POS_LIM47  = 47'h7FFF_FFFF_FFFF;

  // register index codes on the configuration port
  typedef enum logic {
    REG_GAS  = 1'b0,
    REG_HEAT = 1'b1
  } reg_idx_t;

  // partial products of a 48 x 48 unsigned multiply split in 24-bit halves
  typedef struct packed {
    logic [47:0] hh;
    logic [47:0] hl;
    logic [47:0] lh;
    logic [47:0] ll;
  } pp_t;

  // data that rides along the divider
  typedef struct packed {
    logic                          bad;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0][DATA_W-1:0]  mag;
    logic [46:0]                   spd2;
  } side_t;

  // divider status toward the top level
  typedef struct packed {
    logic valid;
    logic ovf;
  } div_stat_t;

  function automatic pp_t mul_pp(logic [47:0] a, logic [47:0] b);
    pp_t r;
    r.hh = a[47:24] * b[47:24];
    r.hl = a[47:24] * b[23:0];
    r.lh = a[23:0] * b[47:24];
    r.ll = a[23:0] * b[23:0];
    return r;
  endfunction

  function automatic logic [PROD_W-1:0] pp_sum(pp_t p);
    logic [48:0] mid;
    mid = {1'b0, p.hl} + {1'b0, p.lh};
    return {p.hh, 48'd0} + {23'd0, mid, 24'd0} + {48'd0, p.ll};
  endfunction

  // magnitude with sign to saturated 48-bit two's complement
  function automatic logic signed [DATA_W-1:0] sat_s(logic [PROD_W:0] m, logic neg);
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] v;
    lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    v = (m > {49'd0, lim}) ? lim : m[DATA_W-1:0];
    return $signed(neg ? (~v + 48'd1) : v);
  endfunction

  function automatic logic [DATA_W-1:0] mag48(logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (~x + 48'd1) : x;
  endfunction

endpackage

[sv/p2c_in_if.sv]
// input channel: one cell of primitive variables
interface p2c_in_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] pressure;
  logic signed [47:0] vel_x;
  logic signed [47:0] vel_y;
  logic signed [47:0] vel_z;
  logic signed [47:0] temperature;
  logic signed [47:0] turb_energy;
  logic signed [47:0] turb_omega;

  modport source (output valid, pressure, vel_x, vel_y, vel_z, temperature,
                  turb_energy, turb_omega, input ready);
  modport sink   (input valid, pressure, vel_x, vel_y, vel_z, temperature,
                  turb_energy, turb_omega, output ready);
endinterface

[sv/p2c_out_if.sv]
// result channel: one cell of conservative variables
interface p2c_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] density;
  logic signed [47:0] mom_x;
  logic signed [47:0] mom_y;
  logic signed [47:0] mom_z;
  logic signed [47:0] total_energy;
  logic signed [47:0] rho_k;
  logic signed [47:0] rho_omega;
  logic               bad_temperature;

  modport source (output valid, density, mom_x, mom_y, mom_z, total_energy, rho_k,
                  rho_omega, bad_temperature, input ready);
  modport sink   (input valid, density, mom_x, mom_y, mom_z, total_energy, rho_k,
                  rho_omega, bad_temperature, output ready);
endinterface

[sv/primitive_to_conservative_3d_top.sv]
// top level: primitive to conservative variable conversion for one mesh cell
//
// in_ch takes one cell of primitive variables (pressure, velocity, temperature,
// turbulence scalars) per transfer; out_ch delivers one cell of conservative
// variables per transfer, in the order the cells came in. All values are signed
// fixed point with FRAC_BITS fraction bits in 48-bit words.
// throughput: one cell per cycle unless stalled; the pipeline is set by the
// restoring divider that forms density and the pressure term of total energy
// the user writes gas constant and heat ratio through the apb port while idle;
// the block does not enforce it; registers at byte address 0 and 8, data 64 bits
// reset: pipeline emptied, registers back to R = 287 and gamma = 1.4
// receiver stall: the whole pipeline holds while the output register is full
// and not taken; in_ch.ready drops in the same cycle, nothing is lost
// a temperature of zero or below returns all zeros with bad_temperature set
module primitive_to_conservative_3d_top #(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  p2c_in_if.sink      in_ch,
  p2c_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int NUM1_W = 48 + 2 * FRAC_BITS;
  localparam int DEN1_W = 94;
  localparam int NUM2_W = 48 + FRAC_BITS;
  localparam int QW     = 48;
  localparam int SIDE_W = $bits(p2c_pkg::side_t);

  // configuration registers
  logic [p2c_pkg::GAS_W-1:0]  gas_r;
  logic [p2c_pkg::HEAT_W-1:0] heat_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_r  <= p2c_pkg::GAS_RESET;
      heat_r <= p2c_pkg::HEAT_RESET;
    end else if (psel && penable && pwrite) begin
      case (p2c_pkg::reg_idx_t'(paddr[3]))
        p2c_pkg::REG_GAS:  gas_r  <= pwdata[p2c_pkg::GAS_W-1:0];
        p2c_pkg::REG_HEAT: heat_r <= pwdata[p2c_pkg::HEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (p2c_pkg::reg_idx_t'(paddr[3]))
      p2c_pkg::REG_GAS:  prdata = {17'd0, gas_r};
      p2c_pkg::REG_HEAT: prdata = {38'd0, heat_r};
      default:           prdata = '0;
    endcase
  end

  // global advance: every stage moves when the output register is free
  logic adv;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage a: capture, magnitudes and signs
  logic                    a_valid_r;
  logic [47:0]             a_p_mag_r, a_t_mag_r;
  logic                    a_p_neg_r, a_bad_r;
  logic [4:0][47:0]        a_mag_r;
  logic [4:0]              a_neg_r;
  logic [4:0][47:0]        in_lane;

  assign in_lane = {in_ch.turb_omega, in_ch.turb_energy, in_ch.vel_z, in_ch.vel_y,
                    in_ch.vel_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_p_mag_r <= p2c_pkg::mag48(in_ch.pressure);
      a_p_neg_r <= in_ch.pressure[47];
      a_t_mag_r <= p2c_pkg::mag48(in_ch.temperature);
      a_bad_r   <= in_ch.temperature[47] || (in_ch.temperature == '0);
      for (int j = 0; j < 5; j++) begin
        a_mag_r[j] <= p2c_pkg::mag48(in_lane[j]);
        a_neg_r[j] <= in_lane[j][47];
      end
    end
  end

  // stage b: partial products of R*T and the velocity squares
  logic             b_valid_r;
  p2c_pkg::pp_t     b_pp_rt_r;
  p2c_pkg::pp_t     b_pp_sq_r [3];
  logic [47:0]      b_p_mag_r;
  logic             b_p_neg_r, b_bad_r;
  logic [4:0][47:0] b_mag_r;
  logic [4:0]       b_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_pp_rt_r <= p2c_pkg::mul_pp({1'b0, gas_r}, a_t_mag_r);
      for (int j = 0; j < 3; j++) begin
        b_pp_sq_r[j] <= p2c_pkg::mul_pp(a_mag_r[j], a_mag_r[j]);
      end
      b_p_mag_r <= a_p_mag_r;
      b_p_neg_r <= a_p_neg_r;
      b_bad_r   <= a_bad_r;
      b_mag_r   <= a_mag_r;
      b_neg_r   <= a_neg_r;
    end
  end

  // stage c: sum partial products
  logic              c_valid_r;
  logic [DEN1_W-1:0] c_den1_r;
  logic [95:0]       c_sq_r [3];
  logic [47:0]       c_p_mag_r;
  logic              c_p_neg_r, c_bad_r;
  logic [4:0][47:0]  c_mag_r;
  logic [4:0]        c_neg_r;
  logic [95:0]       rt_full;

  assign rt_full = p2c_pkg::pp_sum(b_pp_rt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_den1_r <= rt_full[DEN1_W-1:0];
      for (int j = 0; j < 3; j++) begin
        c_sq_r[j] <= p2c_pkg::pp_sum(b_pp_sq_r[j]);
      end
      c_p_mag_r <= b_p_mag_r;
      c_p_neg_r <= b_p_neg_r;
      c_bad_r   <= b_bad_r;
      c_mag_r   <= b_mag_r;
      c_neg_r   <= b_neg_r;
    end
  end

  // stage d: speed squared, divisor for the pressure term
  logic                      d_valid_r;
  logic [DEN1_W-1:0]         d_den1_r;
  logic [p2c_pkg::HEAT_W-1:0] d_den2_r;
  logic [46:0]               d_spd2_r;
  logic [47:0]               d_p_mag_r;
  logic                      d_p_neg_r, d_bad_r;
  logic [4:0][47:0]          d_mag_r;
  logic [4:0]                d_neg_r;
  logic [97:0]               sq_tot, sq_sh;
  logic [63:0]               one_w, heat_w;

  assign sq_tot = {2'd0, c_sq_r[0]} + {2'd0, c_sq_r[1]} + {2'd0, c_sq_r[2]};
  assign sq_sh  = sq_tot >> FRAC_BITS;
  assign one_w  = 64'd1 << FRAC_BITS;
  assign heat_w = {38'd0, heat_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (adv) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_den1_r  <= c_den1_r;
      d_den2_r  <= (heat_w > one_w) ? p2c_pkg::HEAT_W'(heat_w - one_w) : '0;
      d_spd2_r  <= (sq_sh > {51'd0, p2c_pkg::POS_LIM47}) ? p2c_pkg::POS_LIM47
                                                         : sq_sh[46:0];
      d_p_mag_r <= c_p_mag_r;
      d_p_neg_r <= c_p_neg_r;
      d_bad_r   <= c_bad_r;
      d_mag_r   <= c_mag_r;
      d_neg_r   <= c_neg_r;
    end
  end

  // dividers: density and the pressure term run side by side
  p2c_pkg::side_t     d_side, v_side;
  logic [SIDE_W-1:0]  v_side_bits;
  p2c_pkg::div_stat_t rho_stat, pt_stat;
  logic [QW-1:0]      rho_q, pt_q;
  logic               v_p_neg;

  assign d_side.bad  = d_bad_r;
  assign d_side.neg  = d_neg_r;
  assign d_side.mag  = d_mag_r;
  assign d_side.spd2 = d_spd2_r;
  assign v_side      = p2c_pkg::side_t'(v_side_bits);

  p2c_div #(
    .NW(NUM1_W), .DW(DEN1_W), .QW(QW), .SIDE_W(SIDE_W)
  ) u_div_rho (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (d_valid_r),
    .num      (NUM1_W'(d_p_mag_r) << (2 * FRAC_BITS)),
    .den      (d_den1_r),
    .side_in  (d_side),
    .stat     (rho_stat),
    .quot     (rho_q),
    .side_out (v_side_bits)
  );

  p2c_div #(
    .NW(NUM2_W), .DW(p2c_pkg::HEAT_W), .QW(QW), .SIDE_W(1)
  ) u_div_pt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (d_valid_r),
    .num      (NUM2_W'(d_p_mag_r) << FRAC_BITS),
    .den      (d_den2_r),
    .side_in  (d_p_neg_r),
    .stat     (pt_stat),
    .quot     (pt_q),
    .side_out (v_p_neg)
  );

  // stage e: saturate quotients
  logic                     e_valid_r;
  logic signed [47:0]       e_rho_r, e_pterm_r;
  logic [47:0]              e_rho_mag_r;
  logic                     e_p_neg_r;
  p2c_pkg::side_t           e_side_r;
  logic signed [47:0]       rho_sat;
  logic [96:0]              rho_m, pt_m;

  assign rho_m   = rho_stat.ovf ? '1 : {49'd0, rho_q};
  assign pt_m    = pt_stat.ovf ? '1 : {49'd0, pt_q};
  assign rho_sat = p2c_pkg::sat_s(rho_m, v_p_neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (adv) begin
      e_valid_r <= rho_stat.valid && pt_stat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_rho_r     <= rho_sat;
      e_rho_mag_r <= p2c_pkg::mag48(rho_sat);
      e_pterm_r   <= p2c_pkg::sat_s(pt_m, v_p_neg);
      e_p_neg_r   <= v_p_neg;
      e_side_r    <= v_side;
    end
  end

  // stage f: partial products of density with each lane and speed squared
  logic               f_valid_r;
  p2c_pkg::pp_t       f_pp_r [6];
  logic signed [47:0] f_rho_r, f_pterm_r;
  logic               f_p_neg_r, f_bad_r;
  logic [4:0]         f_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (adv) begin
      f_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 5; j++) begin
        f_pp_r[j] <= p2c_pkg::mul_pp(e_rho_mag_r, e_side_r.mag[j]);
      end
      f_pp_r[5] <= p2c_pkg::mul_pp(e_rho_mag_r, {1'b0, e_side_r.spd2});
      f_rho_r   <= e_rho_r;
      f_pterm_r <= e_pterm_r;
      f_p_neg_r <= e_p_neg_r;
      f_bad_r   <= e_side_r.bad;
      f_neg_r   <= e_side_r.neg;
    end
  end

  // stage g: full products
  logic               g_valid_r;
  logic [95:0]        g_prod_r [6];
  logic signed [47:0] g_rho_r, g_pterm_r;
  logic               g_p_neg_r, g_bad_r;
  logic [4:0]         g_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else if (adv) begin
      g_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 6; j++) begin
        g_prod_r[j] <= p2c_pkg::pp_sum(f_pp_r[j]);
      end
      g_rho_r   <= f_rho_r;
      g_pterm_r <= f_pterm_r;
      g_p_neg_r <= f_p_neg_r;
      g_bad_r   <= f_bad_r;
      g_neg_r   <= f_neg_r;
    end
  end

  // stage h: rescale and saturate products; kinetic term takes the extra halving
  logic               h_valid_r;
  logic signed [47:0] h_res_r [5];
  logic signed [47:0] h_ke_r, h_rho_r, h_pterm_r;
  logic               h_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r <= 1'b0;
    end else if (adv) begin
      h_valid_r <= g_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 5; j++) begin
        h_res_r[j] <= p2c_pkg::sat_s({1'b0, g_prod_r[j] >> FRAC_BITS},
                                     g_p_neg_r ^ g_neg_r[j]);
      end
      h_ke_r    <= p2c_pkg::sat_s({1'b0, g_prod_r[5] >> (FRAC_BITS + 1)}, g_p_neg_r);
      h_rho_r   <= g_rho_r;
      h_pterm_r <= g_pterm_r;
      h_bad_r   <= g_bad_r;
    end
  end

  // output register: energy sum and bad temperature override
  logic signed [48:0] e_sum;
  logic signed [47:0] e_sat;
  logic signed [47:0] out_rho_r, out_mx_r, out_my_r, out_mz_r, out_en_r, out_rk_r, out_ro_r;
  logic               out_bad_r;

  assign e_sum = {h_pterm_r[47], h_pterm_r} + {h_ke_r[47], h_ke_r};
  always_comb begin
    if (e_sum > 49'sh0_7FFF_FFFF_FFFF) begin
      e_sat = 48'sh7FFF_FFFF_FFFF;
    end else if (e_sum < -49'sh0_8000_0000_0000) begin
      e_sat = -48'sh8000_0000_0000;
    end else begin
      e_sat = e_sum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= h_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_bad_r <= h_bad_r;
      out_rho_r <= h_bad_r ? '0 : h_rho_r;
      out_mx_r  <= h_bad_r ? '0 : h_res_r[0];
      out_my_r  <= h_bad_r ? '0 : h_res_r[1];
      out_mz_r  <= h_bad_r ? '0 : h_res_r[2];
      out_rk_r  <= h_bad_r ? '0 : h_res_r[3];
      out_ro_r  <= h_bad_r ? '0 : h_res_r[4];
      out_en_r  <= h_bad_r ? '0 : e_sat;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.density         = out_rho_r;
  assign out_ch.mom_x           = out_mx_r;
  assign out_ch.mom_y           = out_my_r;
  assign out_ch.mom_z           = out_mz_r;
  assign out_ch.total_energy    = out_en_r;
  assign out_ch.rho_k           = out_rk_r;
  assign out_ch.rho_omega       = out_ro_r;
  assign out_ch.bad_temperature = out_bad_r;

`ifndef SYNTHESIS
  // a bad temperature result carries only zeros
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_rho_r == '0 && out_en_r == '0 && out_mx_r == '0)
    else $error("bad temperature result not cleared");

  // zero density gives zero momenta and turbulence products
  a_rho_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rho_r == '0 |-> out_mx_r == '0 && out_my_r == '0 &&
      out_mz_r == '0 && out_rk_r == '0 && out_ro_r == '0)
    else $error("product of zero density not zero");

  // a stalled pipeline keeps its last stage
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(h_valid_r) && $stable(h_rho_r))
    else $error("pipeline moved during stall");

  // both dividers stay in step
  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    rho_stat.valid == pt_stat.valid)
    else $error("dividers out of step");
`endif

endmodule

[sv/p2c_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow detect
module p2c_div #(
  parameter int NW     = 96,
  parameter int DW     = 94,
  parameter int QW     = 48,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [NW-1:0]        num,
  input  logic [DW-1:0]        den,
  input  logic [SIDE_W-1:0]    side_in,
  output p2c_pkg::div_stat_t   stat,
  output logic [QW-1:0]        quot,
  output logic [SIDE_W-1:0]    side_out
);

  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;
  localparam int NS = QW + 1;

  logic              vld_r  [NS];
  logic              ovf_r  [NS];
  logic              zero_r [NS];
  logic [NW-1:0]     rem_r  [NS];
  logic [DW-1:0]     den_r  [NS];
  logic [QW-1:0]     q_r    [NS];
  logic [SIDE_W-1:0] side_r [NS];

  logic in_zero;
  logic in_ovf;

  assign in_zero = (num == '0);
  assign in_ovf  = !in_zero && (CW'(num) >= (CW'(den) << QW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_r[0]  <= in_ovf;
      zero_r[0] <= in_zero;
      rem_r[0]  <= num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    localparam int B = QW - k;
    logic [CW-1:0] dsh;
    logic          ge;

    assign dsh = CW'(den_r[k-1]) << B;
    assign ge  = CW'(rem_r[k-1]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ovf_r[k]  <= ovf_r[k-1];
        zero_r[k] <= zero_r[k-1];
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
        rem_r[k]  <= ge ? NW'(CW'(rem_r[k-1]) - dsh) : rem_r[k-1];
        q_r[k]    <= ge ? (q_r[k-1] | (QW'(1) << B)) : q_r[k-1];
      end
    end
  end

  assign stat.valid = vld_r[NS-1];
  assign stat.ovf   = ovf_r[NS-1];
  assign quot       = zero_r[NS-1] ? '0 : q_r[NS-1];
  assign side_out   = side_r[NS-1];

endmodule

[tb/primitive_to_conservative_3d_top_tb.sv]
// testbench for the primitive to conservative conversion block
`timescale 1ns / 1ps

module primitive_to_conservative_3d_top_tb;

  localparam int unsigned FRAC      = 24;
  localparam int unsigned LATENCY   = 58;
  localparam int unsigned CYCLE_CAP = 400000;

  typedef logic [255:0] wide_t;

  typedef struct packed {
    logic signed [47:0] pressure;
    logic signed [47:0] vel_x;
    logic signed [47:0] vel_y;
    logic signed [47:0] vel_z;
    logic signed [47:0] temperature;
    logic signed [47:0] turb_energy;
    logic signed [47:0] turb_omega;
  } cell_t;

  typedef struct packed {
    logic signed [47:0] density;
    logic signed [47:0] mom_x;
    logic signed [47:0] mom_y;
    logic signed [47:0] mom_z;
    logic signed [47:0] total_energy;
    logic signed [47:0] rho_k;
    logic signed [47:0] rho_omega;
    logic               bad_temperature;
  } cons_t;

  // conservative-variable predictor and store of expected cells
  class cons_scoreboard;
    logic [p2c_pkg::GAS_W-1:0]  gas;
    logic [p2c_pkg::HEAT_W-1:0] heat;
    cons_t                      expected_cells[$];
    int                         mismatches;

    function void set_regs(logic [p2c_pkg::GAS_W-1:0] r, logic [p2c_pkg::HEAT_W-1:0] g);
      gas  = r;
      heat = g;
    endfunction

    function wide_t absw(logic signed [47:0] x);
      logic signed [48:0] e;
      e = x;
      if (e < 0) e = -e;
      return {207'd0, e};
    endfunction

    function logic signed [47:0] clamp(wide_t m, bit neg);
      wide_t       lim;
      wide_t       v;
      logic [47:0] r;
      lim = neg ? (wide_t'(1) << 47) : ((wide_t'(1) << 47) - 1);
      v = (m > lim) ? lim : m;
      r = v[47:0];
      if (neg) r = -r;
      return r;
    endfunction

    function logic signed [47:0] fmul(logic signed [47:0] a, logic signed [47:0] b,
                                      int unsigned sh);
      return clamp((absw(a) * absw(b)) >> sh, (a < 0) != (b < 0));
    endfunction

    function logic signed [47:0] fdiv(wide_t num, wide_t den, bit neg);
      if (den == 0) return (num == 0) ? 48'sd0 : clamp({256{1'b1}}, neg);
      return clamp(num / den, neg);
    endfunction

    function cons_t convert(cell_t c);
      cons_t              r;
      wide_t              one, hden, sq;
      logic signed [47:0] rho, pterm, ke;
      logic signed [49:0] sum;
      r = '0;
      if (c.temperature <= 0) begin
        r.bad_temperature = 1'b1;
        return r;
      end
      one = wide_t'(1) << FRAC;
      rho = fdiv(absw(c.pressure) << (2 * FRAC), {209'd0, gas} * absw(c.temperature),
                 c.pressure < 0);
      hden = ({230'd0, heat} > one) ? ({230'd0, heat} - one) : 0;
      pterm = fdiv(absw(c.pressure) << FRAC, hden, c.pressure < 0);
      sq = (absw(c.vel_x) * absw(c.vel_x) + absw(c.vel_y) * absw(c.vel_y) +
            absw(c.vel_z) * absw(c.vel_z)) >> FRAC;
      if (sq > {209'd0, p2c_pkg::POS_LIM47}) sq = {209'd0, p2c_pkg::POS_LIM47};
      ke = clamp((absw(rho) * sq) >> (FRAC + 1), rho < 0);
      sum = pterm + ke;
      if (sum > 50'sh0_7FFF_FFFF_FFFF) sum = 50'sh0_7FFF_FFFF_FFFF;
      if (sum < -50'sh0_8000_0000_0000) sum = -50'sh0_8000_0000_0000;
      r.density      = rho;
      r.mom_x        = fmul(rho, c.vel_x, FRAC);
      r.mom_y        = fmul(rho, c.vel_y, FRAC);
      r.mom_z        = fmul(rho, c.vel_z, FRAC);
      r.total_energy = sum[47:0];
      r.rho_k        = fmul(rho, c.turb_energy, FRAC);
      r.rho_omega    = fmul(rho, c.turb_omega, FRAC);
      return r;
    endfunction

    function void note_cell(cell_t c);
      expected_cells.push_back(convert(c));
    endfunction

    function void report(string field, logic [47:0] e, logic [47:0] a);
      $display("%0t: %s expected %h actual %h", $time, field, e, a);
      mismatches++;
    endfunction

    function void check_cell(cons_t a);
      cons_t e;
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, a);
        mismatches++;
        return;
      end
      e = expected_cells.pop_front();
      if (a.density !== e.density) report("density", e.density, a.density);
      if (a.mom_x !== e.mom_x) report("mom_x", e.mom_x, a.mom_x);
      if (a.mom_y !== e.mom_y) report("mom_y", e.mom_y, a.mom_y);
      if (a.mom_z !== e.mom_z) report("mom_z", e.mom_z, a.mom_z);
      if (a.total_energy !== e.total_energy)
        report("total_energy", e.total_energy, a.total_energy);
      if (a.rho_k !== e.rho_k) report("rho_k", e.rho_k, a.rho_k);
      if (a.rho_omega !== e.rho_omega) report("rho_omega", e.rho_omega, a.rho_omega);
      if (a.bad_temperature !== e.bad_temperature)
        report("bad_temperature", 48'(e.bad_temperature), 48'(a.bad_temperature));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  bit          idling_on;   // cleared for the stretch with no idling at all
  int unsigned cycle_count = 0;

  p2c_in_if  in_ch ();
  p2c_out_if out_ch ();

  cons_scoreboard sb;

  primitive_to_conservative_3d_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // watchdog on a free-running cycle count
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random backpressure, changed on the falling edge only
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(idling_on && $urandom_range(99) < 20);
  end

  // monitors on the rising edge: accepted cells feed the predictor, results are checked
  always @(posedge clk) begin
    cell_t c;
    cons_t a;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      c = '{in_ch.pressure, in_ch.vel_x, in_ch.vel_y, in_ch.vel_z, in_ch.temperature,
            in_ch.turb_energy, in_ch.turb_omega};
      sb.note_cell(c);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = '{out_ch.density, out_ch.mom_x, out_ch.mom_y, out_ch.mom_z, out_ch.total_energy,
            out_ch.rho_k, out_ch.rho_omega, out_ch.bad_temperature};
      sb.check_cell(a);
    end
  end

  // apb write: setup cycle then access cycle, register taken at the access edge
  task automatic apb_write(p2c_pkg::reg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 4'(idx) << 3;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(logic [p2c_pkg::GAS_W-1:0] r, logic [p2c_pkg::HEAT_W-1:0] g);
    apb_write(p2c_pkg::REG_GAS, {17'd0, r});
    apb_write(p2c_pkg::REG_HEAT, {38'd0, g});
    sb.set_regs(r, g);
  endtask

  // one input transfer, with a random gap in front of it
  task automatic send_cell(cell_t c);
    @(negedge clk);
    while (idling_on && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pressure    <= c.pressure;
    in_ch.vel_x       <= c.vel_x;
    in_ch.vel_y       <= c.vel_y;
    in_ch.vel_z       <= c.vel_z;
    in_ch.temperature <= c.temperature;
    in_ch.turb_energy <= c.turb_energy;
    in_ch.turb_omega  <= c.turb_omega;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // wait until every expected cell has come back, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_cells.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // random value spread over all magnitudes, sometimes at the extremes
  function automatic logic signed [47:0] rnd_val();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    case ($urandom_range(9))
      0: v = 48'h7FFF_FFFF_FFFF;
      1: v = 48'h8000_0000_0000;
      2: v = 48'd0;
      3, 4: ;
      default: begin
        v = v >> $urandom_range(47);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic cell_t rnd_cell();
    cell_t c;
    c = '{rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val()};
    // mostly physical temperatures so the arithmetic path is exercised
    if ($urandom_range(9) != 0) begin
      if (c.temperature < 0) c.temperature = -c.temperature;
      if (c.temperature <= 0) c.temperature = 48'sd1 + 48'($urandom_range(1 << 26));
    end
    return c;
  endfunction

  localparam logic signed [47:0] PMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] PMIN = 48'sh8000_0000_0000;
  localparam logic signed [47:0] ONE  = 48'sd1 << 24;

  initial begin
    cell_t directed[$];
    sb = new();
    sb.set_regs(p2c_pkg::GAS_RESET, p2c_pkg::HEAT_RESET);
    idling_on = 1'b1;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.pressure = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.vel_z = '0;
    in_ch.temperature = '0;
    in_ch.turb_energy = '0;
    in_ch.turb_omega = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed cells at reset settings: extremes and bad temperatures
    directed = '{
      '{ONE * 100000, ONE * 10, -ONE * 5, ONE, ONE * 300, ONE, ONE * 2},
      '{PMAX, PMAX, PMAX, PMAX, 48'sd1, PMAX, PMAX},
      '{PMIN, PMIN, PMIN, PMIN, 48'sd1, PMIN, PMIN},
      '{PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX},
      '{48'sd0, PMAX, PMIN, PMAX, ONE, PMAX, PMIN},
      '{ONE, 48'sd0, 48'sd0, 48'sd0, ONE, 48'sd0, 48'sd0},
      '{ONE, ONE, ONE, ONE, 48'sd0, ONE, ONE},
      '{ONE, ONE, ONE, ONE, -48'sd1, ONE, ONE},
      '{PMAX, PMAX, PMAX, PMAX, PMIN, PMAX, PMAX},
      '{-ONE * 1000, 48'sd1, -48'sd1, 48'sd1, PMAX, -48'sd1, 48'sd1},
      '{48'sd1, 48'sd1, 48'sd1, 48'sd1, 48'sd1, 48'sd1, 48'sd1},
      '{-48'sd1, -48'sd1, -48'sd1, -48'sd1, 48'sd1, -48'sd1, -48'sd1}
    };
    foreach (directed[i]) send_cell(directed[i]);
    drain();

    // register extremes, reset settings, then random settings; one phase runs with no idling
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_regs(47'd1, 26'd50331648);
        1: set_regs(47'h7FFF_FFFF_FFFF, 26'd16777217);
        2: set_regs(p2c_pkg::GAS_RESET, p2c_pkg::HEAT_RESET);
        3: begin
          set_regs(47'($urandom_range(1 << 30) + 1),
                   26'd16777217 + 26'($urandom_range(33554431)));
          idling_on = 1'b0;
        end
        default: set_regs(47'({$urandom, $urandom} >> $urandom_range(46)) | 47'd1,
                          26'd16777217 + 26'($urandom_range(33554431)));
      endcase
      repeat (62) send_cell(rnd_cell());
      drain();
      idling_on = 1'b1;
    end

    if (sb.mismatches == 0 && sb.expected_cells.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
